// ===== hw/rtl/dvrt_pkg.sv =====
// Package for the distance-vector route table: field types, codes and states.
// No dependencies.
`timescale 1ns / 1ps
package dvrt_pkg;

	typedef enum logic [1:0] {
		FUNC_UPDATE = 2'd0,
		FUNC_LOOKUP = 2'd1,
		FUNC_AGE    = 2'd2,
		FUNC_EXPORT = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ACT_UPDATE_DONE = 3'd0,
		ACT_DELIVER     = 3'd1,
		ACT_FORWARD     = 3'd2,
		ACT_TTL_EXCEED  = 3'd3,
		ACT_NO_ROUTE    = 3'd4,
		ACT_VECTOR      = 3'd5,
		ACT_TABLE_FULL  = 3'd6,
		ACT_AGE_DONE    = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		CFG_OWN_ID       = 2'd0,
		CFG_AGE_LIMIT    = 2'd1,
		CFG_METRIC_LIMIT = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_AGE,
		ST_EXPORT,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic [7:0]  dest;
		logic [4:0]  metric;
		logic [7:0]  hop_id;
		logic [31:0] hop_ipv4;
		logic [15:0] hop_port;
		logic [31:0] stamp;
	} route_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  entry_dest;
		logic [4:0]  entry_metric;
		logic [7:0]  hop_id;
		logic [31:0] hop_ipv4;
		logic [15:0] hop_port;
		logic [7:0]  ttl_out;
		logic        last_out;
	} result_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  dest_id;
		logic [4:0]  metric_in;
		logic [7:0]  neighbor_id;
		logic [31:0] neighbor_ipv4;
		logic [15:0] neighbor_port;
		logic [7:0]  ttl_in;
		logic [31:0] now_seconds;
		logic        last_in_vector;
	} request_t;

	// control from sequencer to each cell
	typedef struct packed {
		logic shift;    // rotate ring one place
		logic load;     // write new route into cell
		logic load_sel; // this cell is the load target (per cell use)
	} cell_ctl_t;

	localparam int CFG_W = 8;

endpackage

// ===== hw/rtl/dvrt_if.sv =====
// Valid/ready channel interface carrying one payload word.
// Depends on nothing; payload type given by parameter.
`timescale 1ns / 1ps
interface dvrt_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/dvrt_cell.sv =====
// One route cell of the ring: holds a route and passes it to the next cell.
// Depends on dvrt_pkg.
`timescale 1ns / 1ps
module dvrt_cell (
	input  logic                clk,
	input  logic                shift,
	input  logic                load,
	input  dvrt_pkg::route_t    load_route,
	input  dvrt_pkg::route_t    prev_route,
	output dvrt_pkg::route_t    route
);
	import dvrt_pkg::*;

	route_t route_q;

	always_ff @(posedge clk) begin
		if (load) begin
			route_q <= load_route;
		end else if (shift) begin
			route_q <= prev_route;
		end
	end

	assign route = route_q;
endmodule

// ===== hw/rtl/distance_vector_route_table_core.sv =====
// Distance-vector route table core. Routes live in a ring of cells that rotates
// one place a cycle while a pass runs and is not held by age or a stalled export;
// cell 0 is the head seen by the sequencer. Update, lookup, export and age each
// make a full ring turn between accept and result. One word at a time.
// Reset clears route count, registers and control; route contents are undefined.
`timescale 1ns / 1ps
module distance_vector_route_table_core #(
	parameter int ROUTE_ENTRIES = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	dvrt_if.sink       req,
	dvrt_if.source     rsp
);
	import dvrt_pkg::*;

	localparam int CW = $clog2(ROUTE_ENTRIES + 1);
	localparam int PW = $clog2(ROUTE_ENTRIES);

	logic [7:0] own_q, age_lim_q;
	logic [4:0] mlim_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q     <= 8'd0;
			age_lim_q <= 8'd5;
			mlim_q    <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_OWN_ID:       own_q     <= cfg_data;
				CFG_AGE_LIMIT:    age_lim_q <= cfg_data;
				CFG_METRIC_LIMIT: mlim_q    <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// ring of cells; cell k takes from cell k+1, cell N-1 takes from cell 0
	route_t cell_r [ROUTE_ENTRIES];
	logic   shift;
	logic   ld_en;
	logic [PW-1:0] ld_idx;
	route_t ld_route;

	for (genvar k = 0; k < ROUTE_ENTRIES; k++) begin : g_cell
		dvrt_cell u_cell (
			.clk        (clk),
			.shift      (shift),
			.load       (ld_en && ld_idx == PW'(k)),
			.load_route (ld_route),
			.prev_route (cell_r[(k + 1) % ROUTE_ENTRIES]),
			.route      (cell_r[k])
		);
	end

	// head = cell 0. Rotation counter pos: head holds logical entry pos.
	state_t state_q, state_d;
	request_t rq_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] pos_q;   // logical index of route at head
	logic [CW-1:0] step_q;  // cells visited this pass
	logic          hit_q;
	logic [PW-1:0] hit_pos_q;
	route_t        hit_r_q;
	result_t       res_q;
	logic          res_v_q;
	logic          emitted_own_q;
	logic          exp_pending_q;
	result_t       exp_buf_q;

	route_t head;
	assign head = cell_r[0];

	logic [5:0] raw;
	logic [4:0] msat;
	assign raw  = {1'b0, rq_q.metric_in} + 6'd1;
	assign msat = (raw > {1'b0, mlim_q}) ? mlim_q : raw[4:0];

	logic stale;
	assign stale = (rq_q.now_seconds - head.stamp) > {24'd0, age_lim_q};

	logic head_live;
	assign head_live = {1'b0, pos_q} < cnt_q;

	logic rsp_free;
	assign rsp_free = !res_v_q || rsp.ready;

	assign req.ready = (state_q == ST_IDLE) && !res_v_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (req.valid && req.ready) begin
				case (func_t'(req.data.func))
					FUNC_AGE:    state_d = ST_AGE;
					FUNC_EXPORT: state_d = ST_EXPORT;
					default:     state_d = ST_SCAN;
				endcase
			end
			ST_SCAN:   if (step_q == CW'(ROUTE_ENTRIES)) state_d = ST_RESULT;
			ST_AGE:    if (step_q == CW'(ROUTE_ENTRIES) && pos_q == '0) state_d = ST_RESULT;
			ST_EXPORT: if (step_q == CW'(ROUTE_ENTRIES) && !exp_pending_q && rsp_free)
				state_d = ST_IDLE;
			ST_RESULT: if (rsp_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// age: a stale head gets overwritten by last entry; ring holds still
	logic [PW-1:0] last_idx;
	assign last_idx = PW'(cnt_q - CW'(1));
	logic age_kill;
	assign age_kill = (state_q == ST_AGE) && head_live && stale
		&& step_q != CW'(ROUTE_ENTRIES);

	// export: head emitted into buffer when it qualifies
	logic exp_hit;
	assign exp_hit = head_live && head.hop_id != rq_q.neighbor_id;
	logic exp_take;
	assign exp_take = (state_q == ST_EXPORT) && emitted_own_q && step_q != CW'(ROUTE_ENTRIES)
		&& (!exp_pending_q || rsp_free);

	// buffered word goes out once the next one is known, or at the end of the turn
	logic exp_flush;
	assign exp_flush = (state_q == ST_EXPORT) && emitted_own_q && exp_pending_q && rsp_free
		&& ((exp_take && exp_hit) || step_q == CW'(ROUTE_ENTRIES));

	result_t exp_word;
	always_comb begin
		exp_word          = exp_buf_q;
		exp_word.last_out = step_q == CW'(ROUTE_ENTRIES);
	end

	logic res_load;
	assign res_load = exp_flush || (state_q == ST_RESULT && rsp_free);

	always_comb begin
		shift = 1'b0;
		case (state_q)
			ST_SCAN:   shift = step_q != CW'(ROUTE_ENTRIES);
			ST_AGE:    shift = !age_kill && !(step_q == CW'(ROUTE_ENTRIES));
			ST_EXPORT: shift = exp_take;
			default:   shift = 1'b0;
		endcase
	end

	// age overwrite of head: copy last entry; last entry location in ring
	// is cell (last_idx - pos_q) mod N
	logic [PW:0] rel;
	logic [PW-1:0] rel_i;
	always_comb begin
		rel = {1'b0, last_idx} - {1'b0, pos_q};
		if (rel[PW]) rel = rel + (PW+1)'(ROUTE_ENTRIES);
		rel_i = rel[PW-1:0];
	end

	// loads: update write (in ST_RESULT at ring home) or age copy
	logic upd_wr;
	logic [PW-1:0] upd_idx;
	always_comb begin
		ld_en    = 1'b0;
		ld_idx   = '0;
		ld_route = cell_r[rel_i];
		if (age_kill) begin
			ld_en  = 1'b1;
			ld_idx = '0;
		end else if (upd_wr) begin
			ld_en    = 1'b1;
			ld_idx   = upd_idx;
			ld_route = '{dest: rq_q.dest_id, metric: msat, hop_id: rq_q.neighbor_id,
				hop_ipv4: rq_q.neighbor_ipv4, hop_port: rq_q.neighbor_port,
				stamp: rq_q.now_seconds};
		end
	end

	// update commit in ST_RESULT: ring is home (pos 0)
	logic upd_ok;
	always_comb begin
		upd_wr  = 1'b0;
		upd_idx = hit_pos_q;
		upd_ok  = 1'b1;
		if (state_q == ST_RESULT && rsp_free && func_t'(rq_q.func) == FUNC_UPDATE
			&& rq_q.dest_id != own_q) begin
			if (!hit_q) begin
				upd_ok  = cnt_q < CW'(ROUTE_ENTRIES);
				upd_wr  = upd_ok;
				upd_idx = PW'(cnt_q);
			end else begin
				upd_wr = (hit_r_q.metric > msat || hit_r_q.hop_id == rq_q.neighbor_id)
					&& raw <= {1'b0, mlim_q};
			end
		end
	end

	result_t fin;
	always_comb begin
		fin = '0;
		fin.last_out = 1'b1;
		case (func_t'(rq_q.func))
			FUNC_UPDATE: fin.action = upd_ok ? ACT_UPDATE_DONE : ACT_TABLE_FULL;
			FUNC_LOOKUP: begin
				fin.entry_dest = rq_q.dest_id;
				if (rq_q.dest_id == own_q) begin
					fin.action  = ACT_DELIVER;
					fin.ttl_out = rq_q.ttl_in;
				end else if (rq_q.ttl_in <= 8'd1) begin
					fin.action = ACT_TTL_EXCEED;
				end else begin
					fin.ttl_out = rq_q.ttl_in - 8'd1;
					if (hit_q) begin
						fin.action       = ACT_FORWARD;
						fin.entry_metric = hit_r_q.metric;
						fin.hop_id       = hit_r_q.hop_id;
						fin.hop_ipv4     = hit_r_q.hop_ipv4;
						fin.hop_port     = hit_r_q.hop_port;
					end else begin
						fin.action = ACT_NO_ROUTE;
					end
				end
			end
			FUNC_AGE: fin.action = ACT_AGE_DONE;
			default:  fin.action = ACT_VECTOR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			pos_q         <= '0;
			step_q        <= '0;
			hit_q         <= 1'b0;
			hit_pos_q     <= '0;
			res_v_q       <= 1'b0;
			emitted_own_q <= 1'b0;
			exp_pending_q <= 1'b0;
			exp_buf_q     <= '0;
		end else begin
			state_q <= state_d;
			if (res_load) res_v_q <= 1'b1;
			else if (rsp.valid && rsp.ready) res_v_q <= 1'b0;
			if (shift) pos_q <= (pos_q == PW'(ROUTE_ENTRIES - 1)) ? '0 : pos_q + PW'(1);
			case (state_q)
				ST_IDLE: if (req.valid && req.ready) begin
					step_q        <= '0;
					hit_q         <= 1'b0;
					emitted_own_q <= 1'b0;
					exp_pending_q <= 1'b0;
				end
				ST_SCAN: if (shift) begin
					step_q <= step_q + CW'(1);
					if (head_live && !hit_q && head.dest == rq_q.dest_id) begin
						hit_q     <= 1'b1;
						hit_pos_q <= pos_q;
					end
				end
				ST_AGE: begin
					if (age_kill) cnt_q <= cnt_q - CW'(1);
					else if (shift) step_q <= step_q + CW'(1);
				end
				ST_EXPORT: begin
					if (!emitted_own_q) begin
						if (rsp_free) begin
							emitted_own_q <= 1'b1;
							exp_pending_q <= 1'b1;
							exp_buf_q     <= '{action: ACT_VECTOR, entry_dest: own_q,
								default: '0};
						end
					end else if (exp_take) begin
						step_q <= step_q + CW'(1);
						if (exp_hit) begin
							exp_buf_q <= '{action: ACT_VECTOR, entry_dest: head.dest,
								entry_metric: head.metric, default: '0};
							exp_pending_q <= 1'b1;
						end
					end else if (exp_flush) begin
						exp_pending_q <= 1'b0;
					end
				end
				ST_RESULT: if (rsp_free && upd_wr && !hit_q) cnt_q <= cnt_q + CW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid && req.ready) rq_q <= req.data;
		if (state_q == ST_SCAN && shift && head_live && !hit_q && head.dest == rq_q.dest_id)
			hit_r_q <= head;
		if (res_load) res_q <= exp_flush ? exp_word : fin;
	end

	assign rsp.valid = res_v_q;
	assign rsp.data  = res_q;
endmodule

// ===== hw/rtl/dvrt_checker.sv =====
// Port-level checker for the route table core, bound to the core module.
// Depends on dvrt_pkg and distance_vector_route_table_core.
`timescale 1ns / 1ps
module dvrt_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input dvrt_pkg::result_t   rsp_data
);
	import dvrt_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result word dropped or changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("new word taken while busy");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.action != ACT_VECTOR |-> rsp_data.last_out)
		else $error("non-export result without last mark");

	a_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !rsp_valid)
		else $error("result shown while idle");
endmodule

bind distance_vector_route_table_core dvrt_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
